[rtl/mnrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnrt_pkg
// Shared types, codes and constants of the mesh neighbor and route table.
// ----------------------------------------------------------------------------
package mnrt_pkg;

	localparam int NEIGHBOR_SLOTS_DEF = 32;
	localparam int ROUTE_SLOTS_DEF    = 32;

	localparam logic [1:0] CMD_RECORD = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_PRUNE  = 2'd2;
	localparam logic [1:0] CMD_COUNT  = 2'd3;

	localparam logic [1:0] CFG_SELF_ID  = 2'd0;
	localparam logic [1:0] CFG_MAX_HOPS = 2'd1;
	localparam logic [1:0] CFG_RT_TMO   = 2'd2;
	localparam logic [1:0] CFG_NBR_TMO  = 2'd3;

	localparam logic [15:0] SELF_ID_RST  = 16'd0;
	localparam logic [7:0]  MAX_HOPS_RST = 8'd8;
	localparam logic [31:0] RT_TMO_RST   = 32'd600000;
	localparam logic [31:0] NBR_TMO_RST  = 32'd300000;

	localparam logic [2:0]        ALL_BANDS  = 3'h7;
	localparam logic signed [7:0] OFF_BAND_S = -8'sd90;
	localparam logic signed [7:0] STR_FLOOR  = -8'sd128;
	localparam logic [1:0]        BAND_ALT   = 2'h3;

	localparam int NBR_W = 16 + 3 + 24 + 32;
	localparam int RT_W  = 16 + 16 + 8 + 8 + 2 + 32;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_NWR,
		S_RWR,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		PH_NADD,
		PH_RELAY_RT,
		PH_RADD,
		PH_BEACON,
		PH_LOOK_N,
		PH_LOOK_R,
		PH_PRUNE,
		PH_COUNT
	} phase_t;

	typedef struct packed {
		logic hit;
		logic older;
		logic younger;
	} cmp_t;

	function automatic logic [1:0] band_slot(input logic [1:0] b);
		return (b == BAND_ALT) ? 2'd0 : b;
	endfunction

endpackage

[rtl/mnrt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnrt_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module mnrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/mnrt_cmp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnrt_cmp
// Shared entry compare unit: id match and wrapping age against a timeout.
// ----------------------------------------------------------------------------
module mnrt_cmp (
	input  logic        ent_vld,
	input  logic [15:0] ent_id,
	input  logic [15:0] key,
	input  logic [31:0] now,
	input  logic [31:0] stamp,
	input  logic [31:0] timeout,
	output mnrt_pkg::cmp_t res
);

	logic [31:0] age;

	always_comb begin
		age         = now - stamp;
		res.hit     = ent_vld && (ent_id == key);
		res.older   = ent_vld && (age > timeout);
		res.younger = ent_vld && (age < timeout);
	end

endmodule

[rtl/mesh_neighbor_route_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_neighbor_route_table
// Neighbor and route tables served one command at a time by a scan sequencer.
// Each scan of a table walks every slot through the registered RAM port.
// Record takes up to four scans and three writes, lookup up to two scans,
// prune and count one scan; done comes in the cycle after the last scan or write.
// One command in flight; busy stays high until the done beat, and
// the receiver cannot stall the done beat.
// Reset clears the valid bits of both tables at once; no clearing pass.
// ----------------------------------------------------------------------------
module mesh_neighbor_route_table #(
	parameter int NEIGHBOR_SLOTS = mnrt_pkg::NEIGHBOR_SLOTS_DEF,
	parameter int ROUTE_SLOTS    = mnrt_pkg::ROUTE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [15:0] node,
	input  logic [15:0] relay,
	input  logic signed [7:0] strength,
	input  logic [1:0]  band_sel,
	input  logic [31:0] now_ms,
	input  logic        is_beacon,
	input  logic [2:0]  beacon_bands,
	output logic        done,
	output logic        status,
	output logic        found,
	output logic [15:0] via_node,
	output logic [1:0]  out_band,
	output logic [5:0]  tally,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	localparam int NIW  = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
	localparam int RIW  = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
	localparam int MAXS = (NEIGHBOR_SLOTS > ROUTE_SLOTS) ? NEIGHBOR_SLOTS : ROUTE_SLOTS;
	localparam int SCW  = $clog2(MAXS + 1);
	localparam logic [SCW-1:0] NLIM = SCW'(NEIGHBOR_SLOTS);
	localparam logic [SCW-1:0] RLIM = SCW'(ROUTE_SLOTS);

	mnrt_pkg::state_t state_q, state_d;
	mnrt_pkg::phase_t phase_q, phase_d;

	logic [15:0] self_q;
	logic [7:0]  maxh_q;
	logic [31:0] rtmo_q, ntmo_q;

	logic [1:0]  cmd_q;
	logic [15:0] node_q, relay_q;
	logic [7:0]  str_q;
	logic [1:0]  band_q;
	logic [31:0] now_q;
	logic        bcn_q;
	logic [2:0]  bmask_q;

	logic [NEIGHBOR_SLOTS-1:0] nvld_q;
	logic [ROUTE_SLOTS-1:0]    rvld_q;

	logic [SCW-1:0] scan_q, idx_s1;
	logic           vld_s1;
	logic           hit_q, free_q;
	logic [SCW-1:0] hit_idx_q, free_idx_q;
	logic [mnrt_pkg::NBR_W-1:0] hn_q;
	logic [mnrt_pkg::RT_W-1:0]  hr_q;
	logic [7:0]     rhops_q;

	logic [mnrt_pkg::NBR_W-1:0] n_rdata, n_wdata;
	logic [mnrt_pkg::RT_W-1:0]  r_rdata, r_wdata;
	logic           n_we, r_we;

	logic           accept, scan_start, scan_end, is_nbr, ent_vld;
	logic [SCW-1:0] lim;
	logic [15:0]    key, ent_id;
	logic [31:0]    stamp, tmo;
	mnrt_pkg::cmp_t cmp;

	logic [7:0]  hop_inc;
	logic [23:0] str_base, str_new;
	logic [1:0]  slot, top_band;
	logic signed [7:0] best_v, bv;
	logic        set_look_n, set_look_r;

	assign accept = start && !busy;
	assign busy   = (state_q != mnrt_pkg::S_IDLE);
	assign done   = (state_q == mnrt_pkg::S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_q <= mnrt_pkg::SELF_ID_RST;
			maxh_q <= mnrt_pkg::MAX_HOPS_RST;
			rtmo_q <= mnrt_pkg::RT_TMO_RST;
			ntmo_q <= mnrt_pkg::NBR_TMO_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				mnrt_pkg::CFG_SELF_ID:  self_q <= cfg_wdata[15:0];
				mnrt_pkg::CFG_MAX_HOPS: maxh_q <= cfg_wdata[7:0];
				mnrt_pkg::CFG_RT_TMO:   rtmo_q <= cfg_wdata;
				mnrt_pkg::CFG_NBR_TMO:  ntmo_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		is_nbr = (phase_q == mnrt_pkg::PH_NADD) || (phase_q == mnrt_pkg::PH_BEACON) ||
		         (phase_q == mnrt_pkg::PH_LOOK_N) || (phase_q == mnrt_pkg::PH_COUNT);
		lim = is_nbr ? NLIM : RLIM;
		if (phase_q == mnrt_pkg::PH_NADD) begin
			key = (relay_q == 16'd0) ? node_q : relay_q;
		end else if (phase_q == mnrt_pkg::PH_RELAY_RT) begin
			key = relay_q;
		end else begin
			key = node_q;
		end
		if (is_nbr) begin
			ent_vld = vld_s1 && nvld_q[idx_s1[NIW-1:0]];
			ent_id  = n_rdata[74:59];
			stamp   = n_rdata[31:0];
		end else begin
			ent_vld = vld_s1 && rvld_q[idx_s1[RIW-1:0]];
			ent_id  = r_rdata[81:66];
			stamp   = r_rdata[31:0];
		end
		tmo      = (phase_q == mnrt_pkg::PH_PRUNE) ? rtmo_q : ntmo_q;
		scan_end = (state_q == mnrt_pkg::S_SCAN) && (scan_q == lim) && !vld_s1;
		hop_inc  = hr_q[49:42] + 8'd1;
	end

	mnrt_cmp u_cmp (
		.ent_vld (ent_vld),
		.ent_id  (ent_id),
		.key     (key),
		.now     (now_q),
		.stamp   (stamp),
		.timeout (tmo),
		.res     (cmp)
	);

	always_comb begin
		best_v   = mnrt_pkg::STR_FLOOR;
		top_band = 2'd0;
		bv       = 8'sd0;
		for (int b = 0; b < 3; b++) begin
			bv = hn_q[32 + 8*b +: 8];
			if (hn_q[56 + b] && (bv > best_v)) begin
				best_v   = bv;
				top_band = 2'(b);
			end
		end
	end

	always_comb begin
		slot     = mnrt_pkg::band_slot(band_q);
		str_base = hit_q ? hn_q[55:32] : 24'd0;
		str_new  = str_base;
		case (slot)
			2'd1:    str_new[15:8]  = str_q;
			2'd2:    str_new[23:16] = str_q;
			default: str_new[7:0]   = str_q;
		endcase
		n_wdata = {key,
		           ((phase_q == mnrt_pkg::PH_BEACON) && hit_q) ? bmask_q : mnrt_pkg::ALL_BANDS,
		           str_new, now_q};
		if (relay_q == 16'd0) begin
			r_wdata = {node_q, node_q, 8'd1,
			           (band_q != 2'd0) ? mnrt_pkg::OFF_BAND_S : str_q, band_q, now_q};
		end else begin
			r_wdata = {node_q, relay_q, rhops_q, str_q, band_q, now_q};
		end
	end

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		scan_start = 1'b0;
		n_we       = 1'b0;
		r_we       = 1'b0;
		set_look_n = 1'b0;
		set_look_r = 1'b0;
		unique case (state_q)
			mnrt_pkg::S_IDLE: begin
				if (accept) begin
					scan_start = 1'b1;
					state_d    = mnrt_pkg::S_SCAN;
					unique case (cmd)
						mnrt_pkg::CMD_RECORD: begin
							if (node == 16'd0 || node == self_q) begin
								if (is_beacon && node != 16'd0) begin
									phase_d = mnrt_pkg::PH_BEACON;
								end else begin
									state_d = mnrt_pkg::S_DONE;
								end
							end else if (relay == 16'd0 || relay != self_q) begin
								phase_d = mnrt_pkg::PH_NADD;
							end else begin
								phase_d = mnrt_pkg::PH_RELAY_RT;
							end
						end
						mnrt_pkg::CMD_LOOKUP: begin
							if (node == 16'd0 || node == self_q) begin
								state_d = mnrt_pkg::S_DONE;
							end else begin
								phase_d = mnrt_pkg::PH_LOOK_N;
							end
						end
						mnrt_pkg::CMD_PRUNE: phase_d = mnrt_pkg::PH_PRUNE;
						default:             phase_d = mnrt_pkg::PH_COUNT;
					endcase
				end
			end
			mnrt_pkg::S_SCAN: begin
				if (scan_end) begin
					unique case (phase_q)
						mnrt_pkg::PH_NADD, mnrt_pkg::PH_BEACON: state_d = mnrt_pkg::S_NWR;
						mnrt_pkg::PH_RADD: state_d = mnrt_pkg::S_RWR;
						mnrt_pkg::PH_RELAY_RT: begin
							scan_start = 1'b1;
							if (hit_q && hop_inc <= maxh_q) begin
								phase_d = mnrt_pkg::PH_RADD;
							end else if (bcn_q) begin
								phase_d = mnrt_pkg::PH_BEACON;
							end else begin
								state_d = mnrt_pkg::S_DONE;
							end
						end
						mnrt_pkg::PH_LOOK_N: begin
							scan_start = 1'b1;
							if (hit_q) begin
								set_look_n = 1'b1;
								state_d    = mnrt_pkg::S_DONE;
							end else begin
								phase_d = mnrt_pkg::PH_LOOK_R;
							end
						end
						mnrt_pkg::PH_LOOK_R: begin
							set_look_r = hit_q;
							state_d    = mnrt_pkg::S_DONE;
						end
						default: state_d = mnrt_pkg::S_DONE;
					endcase
				end
			end
			mnrt_pkg::S_NWR: begin
				n_we       = hit_q || (free_q && key != self_q);
				scan_start = 1'b1;
				state_d    = mnrt_pkg::S_SCAN;
				if (phase_q == mnrt_pkg::PH_BEACON) begin
					state_d = mnrt_pkg::S_DONE;
				end else if (relay_q == 16'd0) begin
					phase_d = mnrt_pkg::PH_RADD;
				end else begin
					phase_d = mnrt_pkg::PH_RELAY_RT;
				end
			end
			mnrt_pkg::S_RWR: begin
				r_we       = hit_q || free_q;
				scan_start = 1'b1;
				if (bcn_q) begin
					phase_d = mnrt_pkg::PH_BEACON;
					state_d = mnrt_pkg::S_SCAN;
				end else begin
					state_d = mnrt_pkg::S_DONE;
				end
			end
			mnrt_pkg::S_DONE: state_d = mnrt_pkg::S_IDLE;
			default:          state_d = mnrt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mnrt_pkg::S_IDLE;
			phase_q <= mnrt_pkg::PH_NADD;
			nvld_q  <= '0;
			rvld_q  <= '0;
			scan_q  <= '0;
			vld_s1  <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			tally   <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (accept) begin
				tally <= '0;
			end
			if (scan_start) begin
				scan_q <= '0;
				vld_s1 <= 1'b0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (state_q == mnrt_pkg::S_SCAN) begin
				vld_s1 <= (scan_q != lim);
				if (scan_q != lim) begin
					scan_q <= scan_q + 1'b1;
				end
				if (cmp.hit && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (vld_s1 && !ent_vld && !free_q) begin
					free_q <= 1'b1;
				end
				if (phase_q == mnrt_pkg::PH_PRUNE && cmp.older) begin
					rvld_q[idx_s1[RIW-1:0]] <= 1'b0;
					tally <= tally + 6'd1;
				end
				if (phase_q == mnrt_pkg::PH_COUNT && cmp.younger) begin
					tally <= tally + 6'd1;
				end
			end
			if (n_we) begin
				nvld_q[hit_q ? hit_idx_q[NIW-1:0] : free_idx_q[NIW-1:0]] <= 1'b1;
			end
			if (r_we) begin
				rvld_q[hit_q ? hit_idx_q[RIW-1:0] : free_idx_q[RIW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (accept) begin
			cmd_q    <= cmd;
			node_q   <= node;
			relay_q  <= relay;
			str_q    <= strength;
			band_q   <= band_sel;
			now_q    <= now_ms;
			bcn_q    <= is_beacon;
			bmask_q  <= beacon_bands;
			status   <= (cmd == mnrt_pkg::CMD_RECORD) && (node == 16'd0 || node == self_q);
			found    <= 1'b0;
			via_node <= 16'd0;
			out_band <= 2'd0;
		end
		if (state_q == mnrt_pkg::S_SCAN && cmp.hit && !hit_q) begin
			hit_idx_q <= idx_s1;
			hn_q      <= n_rdata;
			hr_q      <= r_rdata;
		end
		if (state_q == mnrt_pkg::S_SCAN && vld_s1 && !ent_vld && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (scan_end && phase_q == mnrt_pkg::PH_RELAY_RT) begin
			rhops_q <= hop_inc;
		end
		if (set_look_n) begin
			found    <= 1'b1;
			via_node <= node_q;
			out_band <= top_band;
		end
		if (set_look_r && cmd_q == mnrt_pkg::CMD_LOOKUP) begin
			found    <= 1'b1;
			via_node <= hr_q[65:50];
			out_band <= hr_q[33:32];
		end
	end

	mnrt_ram #(.WIDTH(mnrt_pkg::NBR_W), .DEPTH(NEIGHBOR_SLOTS)) u_nbr_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (hit_q ? hit_idx_q[NIW-1:0] : free_idx_q[NIW-1:0]),
		.wdata (n_wdata),
		.raddr (scan_q[NIW-1:0]),
		.rdata (n_rdata)
	);

	mnrt_ram #(.WIDTH(mnrt_pkg::RT_W), .DEPTH(ROUTE_SLOTS)) u_rt_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (hit_q ? hit_idx_q[RIW-1:0] : free_idx_q[RIW-1:0]),
		.wdata (r_wdata),
		.raddr (scan_q[RIW-1:0]),
		.rdata (r_rdata)
	);

endmodule

[rtl/mnrt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnrt_checker
// Port level checks of the command handshake and result beats.
// ----------------------------------------------------------------------------
module mnrt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        status,
	input logic        found,
	input logic [15:0] via_node,
	input logic [1:0]  out_band
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result beat while idle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("command not taken");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result beat");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> via_node == 16'd0 && out_band == 2'd0)
		else $error("lookup fields set without a hit");

	a_status_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> !found) else $error("record and lookup fields both set");

endmodule

bind mesh_neighbor_route_table mnrt_checker u_mnrt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.status   (status),
	.found    (found),
	.via_node (via_node),
	.out_band (out_band)
);
